/* design/kbsc_pkg.sv */
package kbsc_pkg;

   localparam int TABLE_DEPTH = 127;
   localparam int PTR_W       = 7;
   localparam int WARM_W      = 12;

   // Entry index that stands for the pointer itself in the 128-byte view.
   localparam logic [PTR_W-1:0] PTR_TOP = 7'd127;

   typedef enum logic [1:0] {
      OP_SEED   = 2'd0,
      OP_KEY    = 2'd1,
      OP_FINISH = 2'd2,
      OP_DATA   = 2'd3
   } kbsc_op_type;

   typedef struct packed {
      logic load_req;
      logic seed_fill;
      logic key_read;
      logic key_write;
      logic step_read_p;
      logic step_read_q;
      logic step_write;
      logic emit;
   } kbsc_cmd_type;

   typedef struct packed {
      logic key_full;
      logic out_free;
   } kbsc_stat_type;

   // Byte of the seed that lands on a table entry, chosen by the entry's low index bits.
   function automatic logic [7:0] seed_byte(input logic [31:0] seed, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = seed[7:0];
         2'd1:    b = seed[15:8];
         2'd2:    b = seed[23:16];
         default: b = seed[31:24];
      endcase
      return b;
   endfunction

endpackage

/* design/kbsc_ctrl.sv */
module kbsc_ctrl #(
   parameter int WARMUP_ROUNDS = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  kbsc_pkg::kbsc_stat_type stat,
   output kbsc_pkg::kbsc_cmd_type  cmd
);
   import kbsc_pkg::*;

   localparam logic [WARM_W-1:0] WARM_LOAD = WARM_W'(WARMUP_ROUNDS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEED   = 7'b0000010,
      S_KEY_RD = 7'b0000100,
      S_KEY_WR = 7'b0001000,
      S_RD_P   = 7'b0010000,
      S_RD_Q   = 7'b0100000,
      S_WR     = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   kbsc_op_type        op_ff, op_in;
   logic [WARM_W-1:0]  warm_left_ff, warm_left_in;
   logic               accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      warm_left_in = warm_left_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = kbsc_op_type'(req_cmd);
               cmd.load_req = 1'b1;
               case (kbsc_op_type'(req_cmd))
                  OP_SEED: state_in = S_SEED;
                  OP_KEY: begin
                     // Key bytes past the last table entry are dropped.
                     if (!stat.key_full) begin
                        state_in = S_KEY_RD;
                     end
                  end
                  OP_FINISH: begin
                     if (WARM_LOAD != '0) begin
                        warm_left_in = WARM_LOAD;
                        state_in     = S_RD_P;
                     end
                  end
                  default: state_in = S_RD_P;
               endcase
            end
         end
         S_SEED: begin
            cmd.seed_fill = 1'b1;
            state_in      = S_IDLE;
         end
         S_KEY_RD: begin
            cmd.key_read = 1'b1;
            state_in     = S_KEY_WR;
         end
         S_KEY_WR: begin
            cmd.key_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_RD_P: begin
            cmd.step_read_p = 1'b1;
            state_in        = S_RD_Q;
         end
         S_RD_Q: begin
            cmd.step_read_q = 1'b1;
            state_in        = S_WR;
         end
         S_WR: begin
            if (op_ff == OP_DATA) begin
               // Hold the write-back until the output register can take the result.
               if (stat.out_free) begin
                  cmd.step_write = 1'b1;
                  cmd.emit       = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.step_write = 1'b1;
               warm_left_in   = warm_left_ff - 1'b1;
               state_in       = (warm_left_ff == WARM_W'(1)) ? S_IDLE : S_RD_P;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_SEED;
         warm_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         warm_left_ff <= warm_left_in;
      end
   end

   a_idle_no_warmup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (warm_left_ff == '0))
      else $error("warm-up count left over while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && (state_in != S_IDLE)) |=> !req_ready)
      else $error("ready stayed high after a request was taken");

   a_emit_only_data: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (op_ff == OP_DATA))
      else $error("result produced for a command that has none");

endmodule

/* design/kbsc_dpath.sv */
module kbsc_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  kbsc_pkg::kbsc_cmd_type  cmd,
   output kbsc_pkg::kbsc_stat_type stat,
   input  logic [31:0]             req_seed_value,
   input  logic [7:0]              req_in_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte
);
   import kbsc_pkg::*;

   logic [7:0]             mem [0:TABLE_DEPTH-1];
   logic [7:0]             mem_q_ff;

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]            fill_seed_ff, fill_seed_in;
   logic [31:0]            seed_req_ff, seed_req_in;
   logic [7:0]             byte_ff, byte_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [PTR_W-1:0]       kpos_ff, kpos_in;
   logic [PTR_W-1:0]       q_ff, q_in;
   logic                   rd_top_ff, rd_top_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [1:0]             rd_idx_ff, rd_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;

   logic [PTR_W-1:0]       addr;
   logic                   rd_en;
   logic                   mem_re;
   logic                   mem_we;
   logic [7:0]             wdata;
   logic [7:0]             eff;
   logic [7:0]             new_byte;
   logic [7:0]             sum;

   // Value of the most recent table read; entries untouched since the seed read as its pattern.
   always_comb begin
      if (rd_top_ff) begin
         eff = {1'b0, PTR_TOP};
      end else if (rd_valid_ff) begin
         eff = mem_q_ff;
      end else begin
         eff = seed_byte(fill_seed_ff, rd_idx_ff);
      end
   end

   assign sum      = {1'b0, ptr_ff} + eff;
   assign q_in     = (sum[PTR_W-1:0] == PTR_TOP) ? '0 : sum[PTR_W-1:0];
   assign new_byte = eff + {1'b0, ptr_ff} + 8'd1;

   always_comb begin
      if (cmd.key_read || cmd.key_write) begin
         addr = kpos_ff;
      end else if (cmd.step_read_p) begin
         addr = ptr_ff;
      end else if (cmd.step_read_q) begin
         addr = q_in;
      end else begin
         addr = q_ff;
      end
   end

   assign rd_en  = cmd.key_read || cmd.step_read_p || cmd.step_read_q;
   assign mem_re = rd_en && (addr != PTR_TOP);
   assign mem_we = cmd.key_write || cmd.step_write;
   assign wdata  = cmd.key_write ? (eff ^ byte_ff) : new_byte;

   always_comb begin
      valid_in     = valid_ff;
      fill_seed_in = fill_seed_ff;
      seed_req_in  = seed_req_ff;
      byte_in      = byte_ff;
      ptr_in       = ptr_ff;
      kpos_in      = kpos_ff;
      rd_top_in    = rd_top_ff;
      rd_valid_in  = rd_valid_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load_req) begin
         seed_req_in = req_seed_value;
         byte_in     = req_in_byte;
      end
      if (cmd.seed_fill) begin
         valid_in     = '0;
         fill_seed_in = seed_req_ff;
         ptr_in       = seed_req_ff[30:24];
         kpos_in      = '0;
      end
      if (rd_en) begin
         rd_top_in   = (addr == PTR_TOP);
         rd_valid_in = (addr == PTR_TOP) ? 1'b0 : valid_ff[addr];
         rd_idx_in   = addr[1:0];
      end
      if (mem_we && (addr != PTR_TOP)) begin
         valid_in[addr] = 1'b1;
      end
      if (cmd.key_write) begin
         kpos_in = kpos_ff + 1'b1;
      end
      if (cmd.step_write) begin
         ptr_in = q_ff;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = byte_ff ^ new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fill_seed_ff <= '0;
         ptr_ff       <= '0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fill_seed_ff <= fill_seed_in;
         ptr_ff       <= ptr_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_req_ff <= seed_req_in;
      byte_ff     <= byte_in;
      rd_top_ff   <= rd_top_in;
      rd_valid_ff <= rd_valid_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      if (cmd.step_read_q) begin
         q_ff <= q_in;
      end
   end

   assign stat.key_full = (kpos_ff == PTR_TOP);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step_write |-> (q_ff != PTR_TOP))
      else $error("keystream write aimed at the pointer slot");

   a_key_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.key_write |-> (kpos_ff != PTR_TOP))
      else $error("key byte written past the table");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_seed_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.seed_fill |=> (valid_ff == '0))
      else $error("table entries still marked written after a seed");

endmodule

/* design/keyed_byte_stream_cipher_core.sv */
// Channel   Ports                                          Direction
// request   req_valid req_ready req_cmd req_seed_value     in
//           req_in_byte
// response  rsp_valid rsp_ready rsp_out_byte               out
//
// A key byte sent once the table is full is accepted and dropped.
// Each keystream step runs on the single-port table memory: read the pointer's
// entry, read the target entry, write it back.
// Reset is synchronous; a seed marks every entry unwritten.
// A data byte waits in its last step while an earlier response is still held.
module keyed_byte_stream_cipher_core #(
   parameter int WARMUP_ROUNDS = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_seed_value,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte
);
   import kbsc_pkg::*;

   kbsc_cmd_type  cmd;
   kbsc_stat_type stat;

   kbsc_ctrl #(
      .WARMUP_ROUNDS(WARMUP_ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .cmd       (cmd)
   );

   kbsc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_seed_value (req_seed_value),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte)
   );

endmodule

/* tb/sv/keyed_byte_stream_cipher_core_test.sv */
`timescale 1ns / 1ps

import kbsc_pkg::*;

class keystream_tracker;
   logic [7:0]       mix [0:TABLE_DEPTH-1];
   logic [PTR_W-1:0] ptr;
   logic [PTR_W-1:0] key_pos;
   logic [7:0]       expected_bytes [$];
   int               warm_rounds;
   int               errors;
   int               results;
   int               seeds;
   int               key_bytes;
   int               finishes;
   int               data_bytes;

   function new(int rounds);
      warm_rounds = rounds;
      foreach (mix[i]) mix[i] = '0;
      ptr        = '0;
      key_pos    = '0;
      errors     = 0;
      results    = 0;
      seeds      = 0;
      key_bytes  = 0;
      finishes   = 0;
      data_bytes = 0;
   endfunction

   // The top entry of the 128-byte view is the pointer itself.
   function logic [7:0] next_keystream();
      logic [PTR_W-1:0] p;
      logic [PTR_W-1:0] q;
      logic [7:0]       v;
      p = ptr;
      v = (p == PTR_TOP) ? {1'b0, p} : mix[p];
      q = p + v[PTR_W-1:0];
      if (q == PTR_TOP) q = '0;
      ptr    = q;
      mix[q] = mix[q] + {1'b0, p} + 8'd1;
      return mix[q];
   endfunction

   // Returns 0 for a request the block ignores: a key byte once the table is full.
   function bit note_request(kbsc_op_type op, logic [31:0] seed, logic [7:0] b);
      bit counted;
      int i;
      counted = 1;
      case (op)
         OP_SEED: begin
            for (i = 0; i < TABLE_DEPTH; i++) mix[i] = seed[8 * (i % 4) +: 8];
            ptr     = seed[30:24];
            key_pos = '0;
            seeds++;
         end
         OP_KEY: begin
            if (key_pos != PTR_TOP) begin
               mix[key_pos] = mix[key_pos] ^ b;
               key_pos++;
               key_bytes++;
            end else begin
               counted = 0;
            end
         end
         OP_FINISH: begin
            repeat (warm_rounds) void'(next_keystream());
            finishes++;
         end
         default: begin
            expected_bytes.push_back(b ^ next_keystream());
            data_bytes++;
         end
      endcase
      return counted;
   endfunction

   function void check_result(logic [7:0] actual);
      logic [7:0] want;
      results++;
      if (expected_bytes.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none, actual 0x%02h", $time, actual);
      end else begin
         want = expected_bytes.pop_front();
         if (actual !== want) begin
            errors++;
            $display("%0t: out_byte mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want, actual);
         end
      end
   endfunction
endclass

module keyed_byte_stream_cipher_core_test;

   localparam int WARM         = 2048;
   localparam int LIMIT        = 1000000;
   localparam int DRAIN_CYCLES = 3 * WARM + 64;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [31:0] req_seed_value;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;

   keystream_tracker tracker = new(WARM);
   int               cycles;
   int               effective_items;
   bit               random_phase;
   bit               hold_request;

   keyed_byte_stream_cipher_core #(
      .WARMUP_ROUNDS(WARM)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_seed_value (req_seed_value),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_out_byte);
   end

   // Response side: random stalls, one steady stretch, and one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (tracker.results >= 100 && tracker.results < 160) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 38);
         end
      end
   end

   task automatic send_request(input kbsc_op_type op, input logic [31:0] seed,
                               input logic [7:0] b);
      bit steady;
      steady = random_phase && effective_items >= 250 && effective_items < 350;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= op;
      req_seed_value <= seed;
      req_in_byte    <= b;
      do @(posedge clock); while (!req_ready);
      if (tracker.note_request(op, seed, b)) effective_items++;
   endtask

   function automatic logic [31:0] pick_seed();
      logic [31:0] s;
      case ($urandom_range(0, 9))
         0:       s = 32'h0000_0000;
         1:       s = 32'hFFFF_FFFF;
         2:       s = {8'h7F, 24'($urandom)};
         default: s = $urandom;
      endcase
      return s;
   endfunction

   initial begin
      int          n_key;
      int          n_data;
      int          i;
      int          pick;
      kbsc_op_type op;

      effective_items = 0;
      random_phase    = 0;
      hold_request    = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = OP_SEED;
      req_seed_value  = '0;
      req_in_byte     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Data on the all-zero table left by reset, then the extreme seeds.
      send_request(OP_DATA, $urandom, 8'h00);
      send_request(OP_DATA, $urandom, 8'hFF);
      send_request(OP_SEED, 32'h0000_0000, 8'($urandom_range(0, 255)));
      send_request(OP_DATA, $urandom, 8'hA5);
      // This seed puts the pointer at the top entry, which then reads itself.
      send_request(OP_SEED, 32'hFFFF_FFFF, 8'($urandom_range(0, 255)));
      send_request(OP_DATA, $urandom, 8'h00);
      send_request(OP_KEY, $urandom, 8'h00);
      send_request(OP_KEY, $urandom, 8'hFF);
      send_request(OP_KEY, $urandom, 8'h5A);
      send_request(OP_FINISH, $urandom, 8'($urandom_range(0, 255)));
      send_request(OP_DATA, $urandom, 8'hFF);
      send_request(OP_KEY, $urandom, 8'h3C);
      send_request(OP_DATA, $urandom, 8'h00);
      send_request(OP_SEED, 32'h8012_3456, 8'($urandom_range(0, 255)));
      send_request(OP_FINISH, $urandom, 8'($urandom_range(0, 255)));
      send_request(OP_FINISH, $urandom, 8'($urandom_range(0, 255)));

      // Hold the response side off while data keeps coming so the input backs up.
      hold_request = 1;
      for (i = 0; i < 8; i++) send_request(OP_DATA, $urandom, 8'($urandom_range(0, 255)));

      effective_items = 0;
      random_phase    = 1;
      while (effective_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 80) begin
            send_request(OP_SEED, pick_seed(), 8'($urandom_range(0, 255)));
            n_key = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 140)
                                                : $urandom_range(0, 32);
            for (i = 0; i < n_key; i++)
               send_request(OP_KEY, $urandom,
                            ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) != 0)
               send_request(OP_FINISH, $urandom, 8'($urandom_range(0, 255)));
            n_data = $urandom_range(4, 40);
            for (i = 0; i < n_data; i++)
               send_request(($urandom_range(0, 9) == 0) ? OP_KEY : OP_DATA,
                            $urandom, 8'($urandom_range(0, 255)));
         end else begin
            n_data = $urandom_range(1, 6);
            for (i = 0; i < n_data; i++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0)      op = OP_FINISH;
               else if (pick < 7)  op = OP_SEED;
               else if (pick < 13) op = OP_KEY;
               else                op = OP_DATA;
               send_request(op, $urandom, 8'($urandom_range(0, 255)));
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.expected_bytes.size() != 0) @(posedge clock);
      // A trailing finish produces no response but keeps the block busy.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d seeds, %0d key bytes and %0d warm-up finishes.",
               tracker.seeds, tracker.key_bytes, tracker.finishes);
      $display("Checked %0d keystream bytes of %0d data requests, %0d mismatches.",
               tracker.results, tracker.data_bytes, tracker.errors);
      if (tracker.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
